// File: src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset disable.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Overlapping implication: antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    `ASSERT_CLK(lbl, clk, rstn, (ante) |-> (cons))

// Non-overlapping implication: antecedent implies consequent in the next cycle.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    `ASSERT_CLK(lbl, clk, rstn, (ante) |=> (cons))

`endif

// File: src/mbe_pkg.sv
// Types and constants of the marker byte escape codec.
// No dependencies.
package mbe_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd3;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [BYTE_W-1:0] NIBBLE_GATE = 8'hF0;
    localparam logic [BYTE_W-1:0] CODE_START  = 8'd1;
    localparam logic [BYTE_W-1:0] CODE_END    = 8'd2;
    localparam logic [BYTE_W-1:0] CODE_ESCAPE = 8'd3;

    localparam logic [BYTE_W-1:0] RST_START  = 8'd250;
    localparam logic [BYTE_W-1:0] RST_END    = 8'd251;
    localparam logic [BYTE_W-1:0] RST_ESCAPE = 8'd252;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] end_marker;
        logic [BYTE_W-1:0] escape_marker;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_last;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
        logic              bad_escape;
    } res_t;

endpackage

// File: src/mbe_cfg.sv
// Configuration register file of the codec.
// Depends on mbe_pkg.
module mbe_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [mbe_pkg::BYTE_W-1:0]       wr_data,
    output mbe_pkg::cfg_t                    cfg,
    output logic                             mode_wr
);

    mbe_pkg::cfg_t cfg_reg;
    mbe_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        mode_wr  = 1'b0;
        if (wr_en)
        begin
            case (wr_index)
                mbe_pkg::REG_MODE:
                begin
                    cfg_next.mode = wr_data[0];
                    mode_wr       = 1'b1;
                end
                mbe_pkg::REG_START:  cfg_next.start_marker  = wr_data;
                mbe_pkg::REG_END:    cfg_next.end_marker    = wr_data;
                mbe_pkg::REG_ESCAPE: cfg_next.escape_marker = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= mbe_pkg::MODE_ENCODE;
            cfg_reg.start_marker  <= mbe_pkg::RST_START;
            cfg_reg.end_marker    <= mbe_pkg::RST_END;
            cfg_reg.escape_marker <= mbe_pkg::RST_ESCAPE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/mbe_core.sv
// Encode/decode logic and decoder frame state.
// Depends on mbe_pkg.
module mbe_core (
    input  logic           clk,
    input  logic           rst_n,
    input  mbe_pkg::cfg_t  cfg,
    input  logic           clear,
    input  logic           take,
    input  mbe_pkg::item_t item,
    output logic [1:0]     res_cnt,
    output mbe_pkg::res_t  res0,
    output mbe_pkg::res_t  res1
);

    logic pending_reg, pending_next;
    logic discard_reg, discard_next;
    logic [mbe_pkg::BYTE_W-1:0] b;
    logic [mbe_pkg::BYTE_W-1:0] code;
    logic last;

    assign b    = item.data_byte;
    assign last = item.frame_last;

    always_comb
    begin
        code = '0;
        if ((b & mbe_pkg::NIBBLE_GATE) == mbe_pkg::NIBBLE_GATE)
        begin
            if (b == cfg.start_marker)
                code = mbe_pkg::CODE_START;
            else if (b == cfg.end_marker)
                code = mbe_pkg::CODE_END;
            else if (b == cfg.escape_marker)
                code = mbe_pkg::CODE_ESCAPE;
        end
    end

    always_comb
    begin
        res_cnt      = 2'd1;
        res0         = '{out_byte: b, out_last: last, bad_escape: 1'b0};
        res1         = '{out_byte: code, out_last: last, bad_escape: 1'b0};
        pending_next = pending_reg;
        discard_next = discard_reg;
        if (cfg.mode == mbe_pkg::MODE_ENCODE)
        begin
            if (code != '0)
            begin
                res_cnt = 2'd2;
                res0    = '{out_byte: cfg.escape_marker, out_last: 1'b0, bad_escape: 1'b0};
            end
        end
        else if (discard_reg)
        begin
            res_cnt = 2'd0;
            if (last)
                discard_next = 1'b0;
        end
        else if (pending_reg)
        begin
            pending_next = 1'b0;
            if (b == mbe_pkg::CODE_START)
                res0.out_byte = cfg.start_marker;
            else if (b == mbe_pkg::CODE_END)
                res0.out_byte = cfg.end_marker;
            else if (b == mbe_pkg::CODE_ESCAPE)
                res0.out_byte = cfg.escape_marker;
            else
            begin
                res0         = '{out_byte: '0, out_last: last, bad_escape: 1'b1};
                discard_next = !last;
            end
        end
        else if (b == cfg.escape_marker)
        begin
            if (last)
                res0 = '{out_byte: '0, out_last: 1'b1, bad_escape: 1'b1};
            else
            begin
                res_cnt      = 2'd0;
                pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            discard_reg <= 1'b0;
        end
        else if (clear)
        begin
            pending_reg <= 1'b0;
            discard_reg <= 1'b0;
        end
        else if (take)
        begin
            pending_reg <= pending_next;
            discard_reg <= discard_next;
        end
    end

endmodule

// File: src/mbe_outq.sv
// Two-entry result queue; slot 0 drives the output port.
// Depends on mbe_pkg.
module mbe_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic [1:0]    load_cnt,
    input  mbe_pkg::res_t load0,
    input  mbe_pkg::res_t load1,
    input  logic          pop,
    output logic          empty_after_pop,
    output logic          head_valid,
    output mbe_pkg::res_t head
);

    logic [1:0]    cnt_reg, cnt_next;
    mbe_pkg::res_t slot0_reg, slot1_reg;

    // load only happens when nothing is left after this cycle's pop
    assign empty_after_pop = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
            cnt_next = load_cnt;
        else if (pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= load0;
            slot1_reg <= load1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign head_valid = (cnt_reg != 2'd0);
    assign head       = slot0_reg;

endmodule

// File: src/marker_byte_escape_codec.sv
// Top level of the marker byte escape codec: input register, coder, result queue.
// Depends on mbe_pkg, mbe_cfg, mbe_core, mbe_outq.
//
//  channel  signals                                    direction
//  in       in_valid in_ready data_byte frame_last     request in
//  out      out_valid out_ready out_byte out_last      request out
//           bad_escape
//  cfg      cfg_valid cfg_ready cfg_index cfg_data     register write in
//
// One request per cycle unless out_ready is low or an encode byte is escaped;
// a request waits in the input register, its results leave via queue slot 0.
// An escaped encode byte holds the next request until its second result drains.
// Asynchronous active-low reset clears queue, input register and decoder state.
// out_ready low stalls the queue and then the input; cfg_ready is always high.
module marker_byte_escape_codec (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mbe_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          frame_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mbe_pkg::BYTE_W-1:0]    out_byte,
    output logic                          out_last,
    output logic                          bad_escape,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbe_pkg::BYTE_W-1:0]    cfg_data
);

    mbe_pkg::cfg_t  cfg;
    logic           mode_wr;
    logic           vld_reg;
    mbe_pkg::item_t item_reg;
    logic           take;
    logic           pop;
    logic           q_room;
    logic [1:0]     res_cnt;
    mbe_pkg::res_t  res0, res1, head;

    assign cfg_ready = 1'b1;

    mbe_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg),
        .mode_wr  (mode_wr)
    );

    assign pop      = out_valid && out_ready;
    assign take     = vld_reg && q_room;
    assign in_ready = !vld_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= '{data_byte: data_byte, frame_last: frame_last};
    end

    mbe_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .clear   (mode_wr),
        .take    (take),
        .item    (item_reg),
        .res_cnt (res_cnt),
        .res0    (res0),
        .res1    (res1)
    );

    mbe_outq u_outq (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (take),
        .load_cnt        (res_cnt),
        .load0           (res0),
        .load1           (res1),
        .pop             (pop),
        .empty_after_pop (q_room),
        .head_valid      (out_valid),
        .head            (head)
    );

    assign out_byte   = head.out_byte;
    assign out_last   = head.out_last;
    assign bad_escape = head.bad_escape;

endmodule

// File: src/mbe_checker.sv
// Port-level checker for the codec, bound to the top level.
// Depends on mbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mbe_pkg::BYTE_W-1:0]    out_byte,
    input logic                          out_last,
    input logic                          bad_escape,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [mbe_pkg::BYTE_W-1:0]    cfg_data
);

    logic mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= mbe_pkg::MODE_ENCODE;
        else if (cfg_valid && cfg_ready && cfg_index == mbe_pkg::REG_MODE)
            mode_reg <= cfg_data[0];
    end

    `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(out_last) && $stable(bad_escape))
    `ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && bad_escape, out_byte == '0)
    `ASSERT_IMP(a_err_decode, clk, rst_n, out_valid && bad_escape,
        mode_reg == mbe_pkg::MODE_DECODE)
    `ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ready, out_valid)

endmodule

bind marker_byte_escape_codec mbe_checker u_mbe_checker (.*);
